@@ sv/tvi_pkg.sv @@
`default_nettype none

package tvi_pkg;

    // Volume geometry and sample format
    localparam int MAX_DIM     = 32;
    localparam int DIM_W       = 6;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int MAX_VOLUMES = 4;
    localparam int VOL_W       = 2;
    localparam int VCFG_W      = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = 17;
    localparam int CORNERS     = 8;
    localparam int CORNER_W    = $clog2(CORNERS);

    // Datapath widths
    localparam int AXW_W  = FRAC_BITS + 1;
    localparam int XY_W   = 2 * AXW_W;
    localparam int WT_W   = 3 * FRAC_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + WT_W + 1;
    localparam int ACC_W  = PROD_W + CORNER_W;
    localparam int RC_W   = 2 * IDX_W + 1;

    // Configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROWS       = 3'd0,
        REG_COLS       = 3'd1,
        REG_PAGES      = 3'd2,
        REG_VOLUMES    = 3'd3,
        REG_BACKGROUND = 3'd4
    } reg_index_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIM_W-1:0]  RST_ROWS    = 6'd32;
    localparam logic [DIM_W-1:0]  RST_COLS    = 6'd32;
    localparam logic [DIM_W-1:0]  RST_PAGES   = 6'd32;
    localparam logic [VCFG_W-1:0] RST_VOLUMES = 3'd1;

    typedef struct packed {
        logic [DIM_W-1:0]              num_rows;
        logic [DIM_W-1:0]              num_cols;
        logic [DIM_W-1:0]              num_pages;
        logic [VCFG_W-1:0]             num_volumes;
        logic signed [SAMPLE_BITS-1:0] background;
    } cfg_t;

    typedef struct packed {
        logic                write_voxel;
        logic                load_query;
        logic                setup_a;
        logic                setup_b;
        logic                issue;
        logic [CORNER_W-1:0] corner;
        logic                clear_acc;
        logic                emit;
        logic                emit_bg;
        logic                next_vol;
    } cmd_t;

    typedef struct packed {
        logic outside;
        logic last_vol;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ sv/tvi_if.sv @@
`default_nettype none

interface tvi_item_if;
    import tvi_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [ADDR_W-1:0]             voxel_address;
    logic signed [SAMPLE_BITS-1:0] voxel_value;
    logic signed [COORD_W-1:0]     coord_x;
    logic signed [COORD_W-1:0]     coord_y;
    logic signed [COORD_W-1:0]     coord_z;

    modport source (
        output valid, operation, voxel_address, voxel_value, coord_x, coord_y, coord_z,
        input  ready
    );

    modport sink (
        input  valid, operation, voxel_address, voxel_value, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

interface tvi_result_if;
    import tvi_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] interpolated;
    logic [VOL_W-1:0]              volume_index;
    logic                          outside;
    logic                          last;

    modport source (
        output valid, interpolated, volume_index, outside, last,
        input  ready
    );

    modport sink (
        input  valid, interpolated, volume_index, outside, last,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/tvi_regs.sv @@
`default_nettype none

module tvi_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tvi_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tvi_pkg::PDATA_W-1:0] pwdata,
    output logic      [tvi_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output tvi_pkg::cfg_t                    cfg
);
    import tvi_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_rows    <= RST_ROWS;
            cfg_reg.num_cols    <= RST_COLS;
            cfg_reg.num_pages   <= RST_PAGES;
            cfg_reg.num_volumes <= RST_VOLUMES;
            cfg_reg.background  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ROWS:       cfg_reg.num_rows    <= pwdata[DIM_W-1:0];
                REG_COLS:       cfg_reg.num_cols    <= pwdata[DIM_W-1:0];
                REG_PAGES:      cfg_reg.num_pages   <= pwdata[DIM_W-1:0];
                REG_VOLUMES:    cfg_reg.num_volumes <= pwdata[VCFG_W-1:0];
                REG_BACKGROUND: cfg_reg.background  <= pwdata[SAMPLE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_ROWS:       prdata = PDATA_W'(cfg_reg.num_rows);
            REG_COLS:       prdata = PDATA_W'(cfg_reg.num_cols);
            REG_PAGES:      prdata = PDATA_W'(cfg_reg.num_pages);
            REG_VOLUMES:    prdata = PDATA_W'(cfg_reg.num_volumes);
            REG_BACKGROUND: prdata = PDATA_W'($unsigned(cfg_reg.background));
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/tvi_ctrl.sv @@
`default_nettype none

module tvi_ctrl (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire logic     item_op,
    input  wire tvi_pkg::status_t status,
    output logic          item_ready,
    output tvi_pkg::cmd_t cmd
);
    import tvi_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SETUP_A = 8'b0000_0010,
        ST_SETUP_B = 8'b0000_0100,
        ST_READ    = 8'b0000_1000,
        ST_DRAIN_A = 8'b0001_0000,
        ST_DRAIN_B = 8'b0010_0000,
        ST_EMIT    = 8'b0100_0000,
        ST_BG      = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        item_ready  = 1'b0;
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_op == OP_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SETUP_A;
                    end
                    else
                    begin
                        cmd.write_voxel = 1'b1;
                    end
                end
            end
            ST_SETUP_A:
            begin
                cmd.setup_a = 1'b1;
                state_next  = ST_SETUP_B;
            end
            ST_SETUP_B:
            begin
                cmd.setup_b   = 1'b1;
                cmd.clear_acc = 1'b1;
                corner_next   = '0;
                state_next    = status.outside ? ST_BG : ST_READ;
            end
            ST_READ:
            begin
                cmd.issue   = 1'b1;
                cmd.corner  = corner_reg;
                corner_next = corner_reg + 1'b1;
                if (corner_reg == CORNER_W'(CORNERS - 1))
                    state_next = ST_DRAIN_A;
            end
            ST_DRAIN_A:
                state_next = ST_DRAIN_B;
            ST_DRAIN_B:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                // hold until the result register frees up
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_vol)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_vol  = 1'b1;
                        cmd.clear_acc = 1'b1;
                        corner_next   = '0;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_BG:
            begin
                if (status.out_free)
                begin
                    cmd.emit_bg = 1'b1;
                    if (status.last_vol)
                        state_next = ST_IDLE;
                    else
                        cmd.next_vol = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/tvi_datapath.sv @@
`default_nettype none

module tvi_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tvi_pkg::cfg_t                          cfg,
    input  wire tvi_pkg::cmd_t                          cmd,
    input  wire logic        [tvi_pkg::ADDR_W-1:0]      voxel_address,
    input  wire logic signed [tvi_pkg::SAMPLE_BITS-1:0] voxel_value,
    input  wire logic signed [tvi_pkg::COORD_W-1:0]     coord_x,
    input  wire logic signed [tvi_pkg::COORD_W-1:0]     coord_y,
    input  wire logic signed [tvi_pkg::COORD_W-1:0]     coord_z,
    input  wire logic                                   res_ready,
    output tvi_pkg::status_t                            status,
    output logic                                        res_valid,
    output logic signed      [tvi_pkg::SAMPLE_BITS-1:0] interpolated,
    output logic             [tvi_pkg::VOL_W-1:0]       volume_index,
    output logic                                        outside,
    output logic                                        last
);
    import tvi_pkg::*;

    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam logic [AXW_W-1:0] ONE_FX = AXW_W'(2 ** FRAC_BITS);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lo);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < lo)
            r = lo;
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    // Clamped extents
    logic [DIM_W-1:0]  rows, cols, pages;
    logic [VCFG_W-1:0] vols;
    logic [VOL_W-1:0]  vols_m1;

    always_comb
    begin
        rows  = clamp_dim(cfg.num_rows, DIM_W'(2));
        cols  = clamp_dim(cfg.num_cols, DIM_W'(2));
        pages = clamp_dim(cfg.num_pages, DIM_W'(1));
        vols  = cfg.num_volumes;
        if (cfg.num_volumes == '0)
            vols = VCFG_W'(1);
        else if (cfg.num_volumes > VCFG_W'(MAX_VOLUMES))
            vols = VCFG_W'(MAX_VOLUMES);
        vols_m1 = VOL_W'(vols - 1'b1);
    end

    // Query coordinates: axis 0 row (y), axis 1 column (x), axis 2 page (z)
    logic signed [COORD_W-1:0] cy_reg, cx_reg, cz_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            cx_reg <= coord_x;
            cy_reg <= coord_y;
            cz_reg <= coord_z;
        end
    end

    // Range and edge tests
    logic [COORD_W-1:0] lim_y, lim_x, lim_z;
    logic               out_y, out_x, out_z;
    logic               edge_y, edge_x, edge_z;
    logic [IDX_W-1:0]   idx_y, idx_x, idx_z;
    logic [AXW_W-1:0]   wy_hi, wy_lo, wx_hi, wx_lo, wz_hi_c, wz_lo_c;

    always_comb
    begin
        lim_y = COORD_W'({rows, {FRAC_BITS{1'b0}}});
        lim_x = COORD_W'({cols, {FRAC_BITS{1'b0}}});
        lim_z = COORD_W'({pages, {FRAC_BITS{1'b0}}});
        // below one: negative or integer part zero
        out_y = cy_reg[COORD_W-1] || (cy_reg[COORD_W-1:FRAC_BITS] == '0)
                || ($unsigned(cy_reg) > lim_y);
        out_x = cx_reg[COORD_W-1] || (cx_reg[COORD_W-1:FRAC_BITS] == '0)
                || ($unsigned(cx_reg) > lim_x);
        out_z = cz_reg[COORD_W-1] || (cz_reg[COORD_W-1:FRAC_BITS] == '0)
                || ($unsigned(cz_reg) > lim_z);
        edge_y = ($unsigned(cy_reg) == lim_y);
        edge_x = ($unsigned(cx_reg) == lim_x);
        edge_z = ($unsigned(cz_reg) == lim_z);
        idx_y = cy_reg[FRAC_BITS +: IDX_W] - 1'b1;
        idx_x = cx_reg[FRAC_BITS +: IDX_W] - 1'b1;
        idx_z = cz_reg[FRAC_BITS +: IDX_W] - 1'b1;
        wy_hi   = AXW_W'(cy_reg[FRAC_BITS-1:0]);
        wx_hi   = AXW_W'(cx_reg[FRAC_BITS-1:0]);
        wz_hi_c = AXW_W'(cz_reg[FRAC_BITS-1:0]);
        wy_lo   = ONE_FX - wy_hi;
        wx_lo   = ONE_FX - wx_hi;
        wz_lo_c = ONE_FX - wz_hi_c;
    end

    // Setup, first step: weights of the row/column plane, partial address
    logic                outside_reg;
    logic [XY_W-1:0]     xy_reg [4];
    logic [AXW_W-1:0]    wz_hi, wz_lo;
    logic                j0_reg;
    logic [DIM_W-1:0]    j1_reg;
    logic                edge_z_reg;
    logic [RC_W-1:0]     rc_reg, row_term_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup_a)
        begin
            outside_reg  <= out_y || out_x || out_z;
            xy_reg[0]    <= XY_W'(wy_lo) * XY_W'(wx_lo);
            xy_reg[1]    <= XY_W'(wy_hi) * XY_W'(wx_lo);
            xy_reg[2]    <= XY_W'(wy_lo) * XY_W'(wx_hi);
            xy_reg[3]    <= XY_W'(wy_hi) * XY_W'(wx_hi);
            wz_hi        <= wz_hi_c;
            wz_lo        <= wz_lo_c;
            j0_reg       <= !edge_y;
            j1_reg       <= edge_x ? '0 : rows;
            edge_z_reg   <= edge_z;
            rc_reg       <= RC_W'(rows) * RC_W'(cols);
            row_term_reg <= RC_W'(idx_y) + RC_W'(rows) * RC_W'(idx_x);
        end
    end

    // Setup, second step, and per-volume advance
    logic [ADDR_W-1:0] base_reg, stride_reg;
    logic [RC_W-1:0]   j2_reg;
    logic [VOL_W-1:0]  vol_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup_b)
        begin
            base_reg   <= ADDR_W'(row_term_reg) + ADDR_W'(rc_reg) * ADDR_W'(idx_z);
            stride_reg <= ADDR_W'(rc_reg) * ADDR_W'(pages);
            j2_reg     <= edge_z_reg ? '0 : rc_reg;
        end
        else if (cmd.next_vol)
        begin
            base_reg <= base_reg + stride_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vol_reg <= '0;
        else if (cmd.load_query)
            vol_reg <= '0;
        else if (cmd.next_vol)
            vol_reg <= vol_reg + 1'b1;
    end

    // Corner address and weight
    logic [ADDR_W-1:0] rd_addr, mem_addr;
    logic [WT_W-1:0]   w_reg;

    always_comb
    begin
        rd_addr = base_reg;
        if (cmd.corner[0])
            rd_addr = rd_addr + ADDR_W'(j0_reg);
        if (cmd.corner[1])
            rd_addr = rd_addr + ADDR_W'(j1_reg);
        if (cmd.corner[2])
            rd_addr = rd_addr + ADDR_W'(j2_reg);
        mem_addr = cmd.write_voxel ? voxel_address : rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
            w_reg <= WT_W'(xy_reg[cmd.corner[1:0]])
                     * WT_W'(cmd.corner[2] ? wz_hi : wz_lo);
    end

    // Single-port voxel memory with registered read
    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_voxel)
            mem[mem_addr] <= voxel_value;
        rdata_reg <= mem[mem_addr];
    end

    // Multiply-accumulate
    logic                     issue_d1_reg, issue_d2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d1_reg <= 1'b0;
            issue_d2_reg <= 1'b0;
        end
        else
        begin
            issue_d1_reg <= cmd.issue;
            issue_d2_reg <= issue_d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_d1_reg)
            prod_reg <= $signed({{(PROD_W-SAMPLE_BITS){rdata_reg[SAMPLE_BITS-1]}}, rdata_reg})
                        * $signed({{(PROD_W-WT_W){1'b0}}, w_reg});
        if (cmd.clear_acc)
            acc_reg <= '0;
        else if (issue_d2_reg)
            acc_reg <= acc_reg + $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});
    end

    // Round to nearest, ties up, then saturate
    logic signed [ACC_W-1:0]       rounded, shifted;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic [ACC_W-SAMPLE_BITS:0]    top_bits;

    always_comb
    begin
        rounded  = acc_reg + $signed(ACC_W'(1) << (3 * FRAC_BITS - 1));
        shifted  = rounded >>> (3 * FRAC_BITS);
        top_bits = shifted[ACC_W-1:SAMPLE_BITS-1];
        if ((top_bits == '0) || (top_bits == '1))
            sat_val = shifted[SAMPLE_BITS-1:0];
        else if (shifted[ACC_W-1])
            sat_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    // Result register
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] res_value_reg;
    logic [VOL_W-1:0]              res_vol_reg;
    logic                          res_outside_reg, res_last_reg;
    logic                          res_load;

    assign res_load = cmd.emit || cmd.emit_bg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_value_reg   <= cmd.emit_bg ? cfg.background : sat_val;
            res_vol_reg     <= vol_reg;
            res_outside_reg <= cmd.emit_bg;
            res_last_reg    <= (vol_reg == vols_m1);
        end
    end

    assign res_valid    = res_valid_reg;
    assign interpolated = res_value_reg;
    assign volume_index = res_vol_reg;
    assign outside      = res_outside_reg;
    assign last         = res_last_reg;

    assign status.outside  = outside_reg;
    assign status.last_vol = (vol_reg == vols_m1);
    assign status.out_free = !res_valid_reg || res_ready;

endmodule

`default_nettype wire

@@ sv/trilinear_volume_interpolator.sv @@
// Write item: accepted while idle, no result.
// Query inside the volume: setup steps A and B, then per volume 8 corner reads from the
// single-port voxel memory and a drain of the multiply-accumulate pipeline before the result
// is emitted; the next item is taken only after the last volume's result. Query outside: one
// background beat per cycle while the result register is free, then the next item is taken.
// Reset clears control state and loads register defaults; the voxel memory is not cleared.
`default_nettype none

module trilinear_volume_interpolator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tvi_item_if.sink                         item,
    tvi_result_if.source                     result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tvi_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tvi_pkg::PDATA_W-1:0] pwdata,
    output logic      [tvi_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import tvi_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    logic    item_ready;

    assign item.ready = item_ready;

    tvi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tvi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_op    (item.operation),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    tvi_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .voxel_address (item.voxel_address),
        .voxel_value   (item.voxel_value),
        .coord_x       (item.coord_x),
        .coord_y       (item.coord_y),
        .coord_z       (item.coord_z),
        .res_ready     (result.ready),
        .status        (status),
        .res_valid     (result.valid),
        .interpolated  (result.interpolated),
        .volume_index  (result.volume_index),
        .outside       (result.outside),
        .last          (result.last)
    );

endmodule

`default_nettype wire

@@ verif/tb_trilinear_volume_interpolator.sv @@
`timescale 1ns / 100ps

module tb_trilinear_volume_interpolator;
    import tvi_pkg::*;

    localparam int DEPTH         = MAX_DIM * MAX_DIM * MAX_DIM * MAX_VOLUMES;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int DRAIN         = 60;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_SHOWN     = 10;
    localparam int PHASES        = 7;
    localparam int PHASE_BEATS   = 60;
    localparam int BURST_QUERIES = 10;
    localparam int DIR_ROWS      = 21;
    localparam int REG_UNUSED_LO = 5;
    localparam int REG_UNUSED_HI = 7;

    typedef struct packed {
        logic                          operation;
        logic [ADDR_W-1:0]             voxel_address;
        logic signed [SAMPLE_BITS-1:0] voxel_value;
        logic signed [COORD_W-1:0]     coord_x;
        logic signed [COORD_W-1:0]     coord_y;
        logic signed [COORD_W-1:0]     coord_z;
    } beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interpolated;
        logic [VOL_W-1:0]              volume_index;
        logic                          outside;
        logic                          last;
    } sample_t;

    // Directed row: a beat plus an optional hand-written expectation
    typedef struct packed {
        logic                          op;
        logic [ADDR_W-1:0]             addr;
        logic signed [SAMPLE_BITS-1:0] value;
        logic signed [COORD_W-1:0]     x;
        logic signed [COORD_W-1:0]     y;
        logic signed [COORD_W-1:0]     z;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] want;
        logic                          out;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    tvi_item_if   item ();
    tvi_result_if result ();

    trilinear_volume_interpolator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the voxel store and the registers
    logic signed [SAMPLE_BITS-1:0] voxels [DEPTH];
    bit                            written [DEPTH];
    logic [DIM_W-1:0]              cfg_rows;
    logic [DIM_W-1:0]              cfg_cols;
    logic [DIM_W-1:0]              cfg_pages;
    logic [VCFG_W-1:0]             cfg_vols;
    logic signed [SAMPLE_BITS-1:0] cfg_bg;
    int                            rows_eff;
    int                            cols_eff;
    int                            pages_eff;
    int                            vols_eff;

    sample_t pending_q [$];
    int      errors    = 0;
    int      shown     = 0;
    int      n_sent    = 0;
    int      n_results = 0;
    int      n_writes  = 0;
    int      n_inside  = 0;
    int      n_outside = 0;
    bit      no_idle   = 1'b0;
    bit      hold_off  = 1'b0;

    always #2 clk = ~clk;

    function automatic void note_fail(input string msg);
        errors++;
        if (shown < MAX_SHOWN)
            $display("%s", msg);
        shown++;
    endfunction

    function automatic int clampi(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void refresh_extents();
        rows_eff  = clampi(int'(cfg_rows), 2, MAX_DIM);
        cols_eff  = clampi(int'(cfg_cols), 2, MAX_DIM);
        pages_eff = clampi(int'(cfg_pages), 1, MAX_DIM);
        vols_eff  = clampi(int'(cfg_vols), 1, MAX_VOLUMES);
    endfunction

    function automatic bit is_inside(input beat_t b);
        return int'(b.coord_y) >= ONE && int'(b.coord_y) <= rows_eff * ONE
            && int'(b.coord_x) >= ONE && int'(b.coord_x) <= cols_eff * ONE
            && int'(b.coord_z) >= ONE && int'(b.coord_z) <= pages_eff * ONE;
    endfunction

    // Axis order: row (y), column (x), page (z); no step at an exact upper edge
    function automatic int corner_address(input beat_t b, input int vol, input int corner);
        int c [3];
        int ext [3];
        int stride [3];
        int a;
        int k;
        c[0]      = int'(b.coord_y);
        c[1]      = int'(b.coord_x);
        c[2]      = int'(b.coord_z);
        ext[0]    = rows_eff;
        ext[1]    = cols_eff;
        ext[2]    = pages_eff;
        stride[0] = 1;
        stride[1] = rows_eff;
        stride[2] = rows_eff * cols_eff;
        a = stride[2] * pages_eff * vol;
        for (k = 0; k < 3; k++)
        begin
            a += stride[k] * ((c[k] >>> FRAC_BITS) - 1);
            if (((corner >> k) & 1) != 0 && c[k] != ext[k] * ONE)
                a += stride[k];
        end
        return a;
    endfunction

    function automatic void predict(input beat_t b);
        longint  acc;
        longint  w;
        longint  r;
        int      fr [3];
        int      v;
        int      corner;
        int      k;
        bit      in;
        sample_t s;
        if (b.operation == OP_WRITE)
        begin
            voxels[b.voxel_address]  = b.voxel_value;
            written[b.voxel_address] = 1'b1;
            n_writes++;
            return;
        end
        in = is_inside(b);
        if (in)
            n_inside++;
        else
            n_outside++;
        fr[0] = int'(b.coord_y) & (ONE - 1);
        fr[1] = int'(b.coord_x) & (ONE - 1);
        fr[2] = int'(b.coord_z) & (ONE - 1);
        for (v = 0; v < vols_eff; v++)
        begin
            if (!in)
                s.interpolated = cfg_bg;
            else
            begin
                acc = 0;
                for (corner = 0; corner < CORNERS; corner++)
                begin
                    w = 1;
                    for (k = 0; k < 3; k++)
                        w *= (((corner >> k) & 1) != 0) ? fr[k] : ONE - fr[k];
                    acc += longint'(voxels[corner_address(b, v, corner)]) * w;
                end
                // round half up, then floor
                r = (acc + (longint'(1) << (3 * FRAC_BITS - 1))) >>> (3 * FRAC_BITS);
                if (r > 32767)
                    r = 32767;
                if (r < -32768)
                    r = -32768;
                s.interpolated = SAMPLE_BITS'(r);
            end
            s.volume_index = VOL_W'(v);
            s.outside      = !in;
            s.last         = (v == vols_eff - 1);
            pending_q.push_back(s);
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic beat_t random_beat(input logic op);
        beat_t b;
        b.operation     = op;
        b.voxel_address = ADDR_W'($urandom);
        b.voxel_value   = SAMPLE_BITS'($urandom);
        b.coord_x       = COORD_W'($urandom);
        b.coord_y       = COORD_W'($urandom);
        b.coord_z       = COORD_W'($urandom);
        return b;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input int ext);
        case ($urandom_range(0, 5))
            0:       return COORD_W'(ONE);
            1:       return COORD_W'(ext * ONE);
            2:       return COORD_W'(ONE * $urandom_range(1, ext));
            default: return COORD_W'($urandom_range(ONE, ext * ONE));
        endcase
    endfunction

    function automatic beat_t inside_query();
        beat_t b;
        b = random_beat(OP_QUERY);
        b.coord_y = pick_coord(rows_eff);
        b.coord_x = pick_coord(cols_eff);
        b.coord_z = pick_coord(pages_eff);
        return b;
    endfunction

    task automatic drive_beat(input beat_t b);
        int gap;
        if (n_sent % 25 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
        n_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            item.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.operation     = b.operation;
        item.voxel_address = b.voxel_address;
        item.voxel_value   = b.voxel_value;
        item.coord_x       = b.coord_x;
        item.coord_y       = b.coord_y;
        item.coord_z       = b.coord_z;
        item.valid         = 1'b1;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task automatic issue(input beat_t b);
        drive_beat(b);
        predict(b);
    endtask

    // Write every corner that a query will read and has never been written, plus some others at random
    task automatic cover_corners(input beat_t q);
        beat_t w;
        int    v;
        int    corner;
        int    a;
        for (v = 0; v < vols_eff; v++)
            for (corner = 0; corner < CORNERS; corner++)
            begin
                a = corner_address(q, v, corner);
                if (!written[a] || $urandom_range(0, 7) == 0)
                begin
                    w = random_beat(OP_WRITE);
                    w.voxel_address = ADDR_W'(a);
                    w.voxel_value   = rand_sample();
                    issue(w);
                end
            end
    endtask

    task automatic settle();
        @(negedge clk);
        item.valid = 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic reg_write(input int idx, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] mask;
        mask = '0;
        case (idx)
            REG_ROWS:
            begin
                cfg_rows = data[DIM_W-1:0];
                mask     = (1 << DIM_W) - 1;
            end
            REG_COLS:
            begin
                cfg_cols = data[DIM_W-1:0];
                mask     = (1 << DIM_W) - 1;
            end
            REG_PAGES:
            begin
                cfg_pages = data[DIM_W-1:0];
                mask      = (1 << DIM_W) - 1;
            end
            REG_VOLUMES:
            begin
                cfg_vols = data[VCFG_W-1:0];
                mask     = (1 << VCFG_W) - 1;
            end
            REG_BACKGROUND:
            begin
                cfg_bg = data[SAMPLE_BITS-1:0];
                mask   = (1 << SAMPLE_BITS) - 1;
            end
            default: ;
        endcase
        refresh_extents();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(idx * 4);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        if (mask != 0)
        begin
            // hold psel and read the same register back
            penable = 1'b0;
            pwrite  = 1'b0;
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if ((prdata & mask) !== (data & mask))
                note_fail($sformatf("register %0d read back %h, expected %h",
                                    idx, prdata & mask, data & mask));
            @(negedge clk);
        end
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        sample_t got;
        sample_t want;
        if (rst_n && result.valid && result.ready)
        begin
            got.interpolated = result.interpolated;
            got.volume_index = result.volume_index;
            got.outside      = result.outside;
            got.last         = result.last;
            n_results++;
            if (pending_q.size() == 0)
                note_fail($sformatf("unexpected result beat: value %0d vol %0d out %b last %b",
                                    got.interpolated, got.volume_index, got.outside, got.last));
            else
            begin
                want = pending_q.pop_front();
                if (got !== want)
                    note_fail($sformatf({"result mismatch: got value %0d vol %0d out %b last %b,",
                                         " expected value %0d vol %0d out %b last %b"},
                                        got.interpolated, got.volume_index, got.outside,
                                        got.last, want.interpolated, want.volume_index,
                                        want.outside, want.last));
            end
        end
    end

    // Result receiver with random stalls and one long hold-off on request
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                result.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_off = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                result.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result.ready = 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        dir_row_t dir_tab [DIR_ROWS];
        int       ph_rows  [PHASES] = '{2, 32, 0, 63, 5, 17, 4};
        int       ph_cols  [PHASES] = '{2, 32, 1, 40, 3, 9, 4};
        int       ph_pages [PHASES] = '{1, 32, 0, 33, 7, 2, 4};
        int       ph_vols  [PHASES] = '{4, 4, 0, 7, 2, 3, 5};
        int       ph_bg    [PHASES] = '{-32768, 32767, 4660, -1, -300, 1000, 77};
        beat_t    b;
        beat_t    burst [$];
        sample_t  s;
        int       i;
        int       ph;
        int       start;
        int       kind;
        int       axis;
        int       lim;
        logic signed [COORD_W-1:0] c;

        item.valid         = 1'b0;
        item.operation     = OP_WRITE;
        item.voxel_address = '0;
        item.voxel_value   = '0;
        item.coord_x       = '0;
        item.coord_y       = '0;
        item.coord_z       = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cfg_rows  = RST_ROWS;
        cfg_cols  = RST_COLS;
        cfg_pages = RST_PAGES;
        cfg_vols  = RST_VOLUMES;
        cfg_bg    = '0;
        refresh_extents();

        // Reset geometry is 32x32x32, one volume, background 0
        dir_tab = '{
            '{OP_WRITE, 17'd0,      16'sh7FFF,  16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd1,      16'sh8000,  16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd32,     16'sd100,   16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd33,     -16'sd100,  16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd1024,   16'sd1,     16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd1025,   -16'sd1,    16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd1056,   16'sd12345, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd1057,  -16'sd12345, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            // exact grid point at the origin corner
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256, 1'b1, 16'sh7FFF, 1'b0},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd384, 16'sd384, 16'sd384, 1'b0, 16'sd0, 1'b0},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd511, 16'sd511, 16'sd257, 1'b0, 16'sd0, 1'b0},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd0,   16'sd256, 16'sd256, 1'b1, 16'sd0, 1'b1},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 16'sd0, 1'b1},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'sd0, 1'b1},
            '{OP_WRITE, 17'd32767,  -16'sd7,    16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
            // upper edge on every axis: all eight corners collapse to one voxel
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd8192, 16'sd8192, 16'sd8192, 1'b1, -16'sd7, 1'b0},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd8193, 16'sd256,  16'sd256,  1'b1, 16'sd0, 1'b1},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd256,  16'sd256,  16'sd255,  1'b1, 16'sd0, 1'b1},
            '{OP_QUERY, 17'd0, 16'sd0, 16'sd256,  16'sd8193, 16'sd256,  1'b1, 16'sd0, 1'b1},
            '{OP_WRITE, 17'd131071, 16'sd21845, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
              1'b0, 16'sd0, 1'b0},
            '{OP_WRITE, 17'd65536, -16'sd21846, 16'sh8000, 16'sh7FFF, 16'sh8000,
              1'b0, 16'sd0, 1'b0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            b.operation     = dir_tab[i].op;
            b.voxel_address = dir_tab[i].addr;
            b.voxel_value   = dir_tab[i].value;
            b.coord_x       = dir_tab[i].x;
            b.coord_y       = dir_tab[i].y;
            b.coord_z       = dir_tab[i].z;
            drive_beat(b);
            if (dir_tab[i].typed)
            begin
                s.interpolated = dir_tab[i].want;
                s.volume_index = '0;
                s.outside      = dir_tab[i].out;
                s.last         = 1'b1;
                pending_q.push_back(s);
                if (dir_tab[i].out)
                    n_outside++;
                else
                    n_inside++;
            end
            else
                predict(b);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            reg_write(REG_ROWS, PDATA_W'(ph_rows[ph]));
            reg_write(REG_COLS, PDATA_W'(ph_cols[ph]));
            reg_write(REG_PAGES, PDATA_W'(ph_pages[ph]));
            reg_write(REG_VOLUMES, PDATA_W'(ph_vols[ph]));
            reg_write(REG_BACKGROUND, PDATA_W'(ph_bg[ph]));
            if (ph == 2)
            begin
                // unmapped addresses: drop silently
                reg_write(REG_UNUSED_LO, PDATA_W'($urandom));
                reg_write(REG_UNUSED_HI, PDATA_W'($urandom));
            end
            start = n_sent;

            if (ph == 0)
            begin
                // Fill the block while the receiver holds off
                burst.delete();
                for (i = 0; i < BURST_QUERIES; i++)
                begin
                    b = inside_query();
                    cover_corners(b);
                    burst.push_back(b);
                end
                hold_off = 1'b1;
                foreach (burst[i])
                    issue(burst[i]);
            end

            while (n_sent - start < PHASE_BEATS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 15)
                begin
                    b = random_beat(OP_WRITE);
                    b.voxel_value = rand_sample();
                end
                else if (kind < 35)
                begin
                    b = random_beat(OP_QUERY);
                    axis = $urandom_range(0, 3);
                    lim = (axis == 0) ? rows_eff : ((axis == 1) ? cols_eff : pages_eff);
                    case ($urandom_range(0, 3))
                        0:       c = COORD_W'(ONE - 1);
                        1:       c = COORD_W'(lim * ONE + 1);
                        2:       c = COORD_W'(-int'($urandom_range(0, 32768)));
                        default: c = COORD_W'($urandom_range(lim * ONE + 1, 32767));
                    endcase
                    case (axis)
                        0:       b.coord_y = c;
                        1:       b.coord_x = c;
                        2:       b.coord_z = c;
                        default: ;
                    endcase
                end
                else
                    b = inside_query();
                if (b.operation == OP_QUERY && is_inside(b))
                    cover_corners(b);
                issue(b);
            end
        end

        settle();
        errors += pending_q.size();
        $display("tb: %0d voxel writes, %0d inside and %0d outside queries, %0d result beats",
                 n_writes, n_inside, n_outside, n_results);
        $display("tb: %0d register settings incl. clamped extents; %0d errors",
                 PHASES + 1, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
